/* hdl/assert_macros.svh */
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the blitter RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");

`endif

/* hdl/ckpb_pkg.sv */
// ---------------------------------------------------------------------------
// ckpb_pkg
// Shared constants and types of the color-keyed palette blitter.
// ---------------------------------------------------------------------------
package ckpb_pkg;

    localparam int DIM_W  = 12;
    localparam int POS_W  = 11;
    localparam int ADDR_W = 22;
    localparam int COLOR_W = 16;
    localparam int INDEX_W = 8;
    localparam int CFG_INDEX_W = 3;

    localparam int MAX_SCREEN_DIM = 2048;
    localparam logic [INDEX_W-1:0] TRANSPARENT_KEY = 8'd255;
    localparam logic [COLOR_W-1:0] SKIP_COLOR = 16'h0000;

    // Operation codes of the input stream
    localparam logic [1:0] OP_PIXEL   = 2'd0;
    localparam logic [1:0] OP_PALETTE = 2'd1;
    localparam logic [1:0] OP_REMAP   = 2'd2;

    // Blit modes
    localparam logic [1:0] MODE_OPAQUE = 2'd0;
    localparam logic [1:0] MODE_KEYED  = 2'd1;
    localparam logic [1:0] MODE_REMAP  = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_DEST_X        = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEST_Y        = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_RECT_WIDTH    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_RECT_HEIGHT   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_SCREEN_WIDTH  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_SCREEN_HEIGHT = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_BLIT_MODE     = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_WIDE_PIXELS   = 3'd7;

    // Per-pixel view of the walk and the settings
    typedef struct packed {
        logic [DIM_W-1:0] row_sum;       // dest_y + row
        logic [DIM_W-1:0] col_sum;       // dest_x + column
        logic [DIM_W-1:0] screen_width;
        logic             bad;
        logic             last;
        logic [1:0]       mode;
        logic             wide;
    } walk_info_t;

endpackage

/* hdl/color_keyed_palette_blit.sv */
// ---------------------------------------------------------------------------
// color_keyed_palette_blit
// Color-keyed rectangle blitter with remap and palette lookup tables.
// ---------------------------------------------------------------------------
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------------
//  input    | in_valid / in_ready  | operation, table_index, table_value, src_pixel
//  output   | out_valid / out_ready| pixel_address, pixel_data, write_enable,
//           |                      | bad_coords, end_of_rect
//  settings | cfg_we               | cfg_index, cfg_data
//
// One transaction per cycle while the output is not stalled; a pixel passes
// stage 1 (remap read at the accepting edge) and then the output register
// (palette read plus address multiply as it leaves stage 1).
// Table loads produce no result.
// Reset sets default settings, clears walk counters and valid flags; table
// contents stay undefined until loaded. No clearing pass.
// A stalled output holds stage 1; input then stalls only while stage 1 is full.
// ---------------------------------------------------------------------------
module color_keyed_palette_blit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // settings
    input  logic                                 cfg_we,
    input  logic [ckpb_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [ckpb_pkg::DIM_W-1:0]           cfg_data,
    // input stream
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [1:0]                           operation,
    input  logic [ckpb_pkg::INDEX_W-1:0]         table_index,
    input  logic [ckpb_pkg::COLOR_W-1:0]         table_value,
    input  logic [ckpb_pkg::INDEX_W-1:0]         src_pixel,
    // result stream
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [ckpb_pkg::ADDR_W-1:0]          pixel_address,
    output logic [ckpb_pkg::COLOR_W-1:0]         pixel_data,
    output logic                                 write_enable,
    output logic                                 bad_coords,
    output logic                                 end_of_rect
);
    import ckpb_pkg::*;
    `include "assert_macros.svh"

    // Lookup tables, one read port each, registered read data
    logic [INDEX_W-1:0] remap_mem   [256];
    logic [COLOR_W-1:0] palette_mem [256];
    logic [INDEX_W-1:0] remap_q_reg;
    logic [COLOR_W-1:0] palette_q_reg;

    walk_info_t info;

    logic in_accept, pixel_accept, s1_adv, s2_free;
    logic transparent;

    // Stage 1: remap read in flight
    logic               s1_valid_reg, s1_valid_next;
    logic               s1_bad_reg, s1_last_reg, s1_we_reg, s1_remap_reg, s1_wide_reg;
    logic [INDEX_W-1:0] s1_pix_reg;
    logic [DIM_W-1:0]   s1_row_sum_reg, s1_col_sum_reg, s1_stride_reg;

    // Stage 2: output register
    logic               s2_valid_reg, s2_valid_next;
    logic               s2_bad_reg, s2_last_reg, s2_we_reg, s2_wide_reg;
    logic [INDEX_W-1:0] s2_index_reg;
    logic [ADDR_W-1:0]  s2_addr_reg;

    logic [INDEX_W-1:0]   s1_index;
    logic [2*DIM_W-1:0]   row_base;
    logic [2*DIM_W-1:0]   addr_full;

    ckpb_walk u_walk (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .step      (pixel_accept),
        .info      (info)
    );

    // Advance a stage only into a free slot; hold stage 1 while a pixel still
    // needs its palette read, so no table load can overtake it.
    assign s2_free      = !s2_valid_reg || out_ready;
    assign s1_adv       = s1_valid_reg && s2_free;
    assign in_ready     = !s1_valid_reg || s2_free;
    assign in_accept    = in_valid && in_ready;
    assign pixel_accept = in_accept && (operation == OP_PIXEL);

    assign transparent = (info.mode != MODE_OPAQUE) && (src_pixel == TRANSPARENT_KEY);

    // Table writes and reads
    always_ff @(posedge clk)
    begin
        if (in_accept && (operation == OP_REMAP))
        begin
            remap_mem[table_index] <= table_value[INDEX_W-1:0];
        end
        if (in_accept && (operation == OP_PALETTE))
        begin
            palette_mem[table_index] <= table_value;
        end
        if (pixel_accept)
        begin
            remap_q_reg <= remap_mem[src_pixel];
        end
        if (s1_adv)
        begin
            // read-before-write: a load accepted at this edge comes later
            palette_q_reg <= palette_mem[s1_index];
        end
    end

    assign s1_index  = s1_remap_reg ? remap_q_reg : s1_pix_reg;
    assign row_base  = s1_row_sum_reg * s1_stride_reg;
    assign addr_full = row_base + {{DIM_W{1'b0}}, s1_col_sum_reg};

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (pixel_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end

        s2_valid_next = s2_valid_reg;
        if (s1_adv)
        begin
            s2_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            s2_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    // Payload registers: no reset
    always_ff @(posedge clk)
    begin
        if (pixel_accept)
        begin
            s1_bad_reg     <= info.bad;
            s1_last_reg    <= info.last;
            s1_we_reg      <= !info.bad && !transparent;
            s1_remap_reg   <= info.mode[1];
            s1_wide_reg    <= info.wide;
            s1_pix_reg     <= src_pixel;
            s1_row_sum_reg <= info.row_sum;
            s1_col_sum_reg <= info.col_sum;
            s1_stride_reg  <= info.screen_width;
        end
        if (s1_adv)
        begin
            s2_bad_reg   <= s1_bad_reg;
            s2_last_reg  <= s1_last_reg;
            s2_we_reg    <= s1_we_reg;
            s2_wide_reg  <= s1_wide_reg;
            s2_index_reg <= s1_index;
            s2_addr_reg  <= s1_bad_reg ? '0 : addr_full[ADDR_W-1:0];
        end
    end

    // Drop the color of skipped pixels; expand through the palette in wide mode
    always_comb
    begin
        if (!s2_we_reg)
        begin
            pixel_data = SKIP_COLOR;
        end
        else if (s2_wide_reg)
        begin
            pixel_data = palette_q_reg;
        end
        else
        begin
            pixel_data = {{(COLOR_W-INDEX_W){1'b0}}, s2_index_reg};
        end
    end

    assign out_valid     = s2_valid_reg;
    assign pixel_address = s2_addr_reg;
    assign write_enable  = s2_we_reg;
    assign bad_coords    = s2_bad_reg;
    assign end_of_rect   = s2_last_reg;

    // A bad rectangle never writes and carries zero address and color
    `ASSERT_IMPLIES(a_bad_quiet, clk, rst_n, out_valid && bad_coords, !write_enable && (pixel_address == '0) && (pixel_data == '0))
    // A skipped pixel carries the skip color
    `ASSERT_IMPLIES(a_skip_color, clk, rst_n, out_valid && !write_enable, pixel_data == SKIP_COLOR)
    // A held stage 1 blocks the input so no table load overtakes a pending read
    `ASSERT_IMPLIES(a_hold_blocks, clk, rst_n, s1_valid_reg && !s2_free, !in_ready)
    // An accepted pixel occupies stage 1 in the next cycle
    `ASSERT_NEXT(a_pixel_enters, clk, rst_n, pixel_accept, s1_valid_reg)

endmodule

/* hdl/ckpb_walk.sv */
// ---------------------------------------------------------------------------
// ckpb_walk
// Settings registers, rectangle walk counters and bounds check.
// ---------------------------------------------------------------------------
module ckpb_walk (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [ckpb_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [ckpb_pkg::DIM_W-1:0]         cfg_data,
    input  logic                               step,
    output ckpb_pkg::walk_info_t               info
);
    import ckpb_pkg::*;

    logic [POS_W-1:0] dest_x_reg, dest_x_next;
    logic [POS_W-1:0] dest_y_reg, dest_y_next;
    logic [DIM_W-1:0] rect_width_reg, rect_width_next;
    logic [DIM_W-1:0] rect_height_reg, rect_height_next;
    logic [DIM_W-1:0] screen_width_reg, screen_width_next;
    logic [DIM_W-1:0] screen_height_reg, screen_height_next;
    logic [1:0]       blit_mode_reg, blit_mode_next;
    logic             wide_pixels_reg, wide_pixels_next;
    logic [POS_W-1:0] col_reg, col_next;
    logic [POS_W-1:0] row_reg, row_next;

    logic             rw_ok, rh_ok, sw_ok, sh_ok;
    logic [DIM_W-1:0] w_eff, h_eff;
    logic             last_col, last_row;
    logic             x_over, y_over;

    function automatic logic dim_ok(input logic [DIM_W-1:0] d);
        return (d != '0) && ({1'b0, d} <= (DIM_W+1)'(MAX_SCREEN_DIM));
    endfunction

    always_comb
    begin
        rw_ok = dim_ok(rect_width_reg);
        rh_ok = dim_ok(rect_height_reg);
        sw_ok = dim_ok(screen_width_reg);
        sh_ok = dim_ok(screen_height_reg);
        w_eff = rw_ok ? rect_width_reg : DIM_W'(1);
        h_eff = rh_ok ? rect_height_reg : DIM_W'(1);
        last_col = ({1'b0, col_reg} + DIM_W'(1)) >= w_eff;
        last_row = ({1'b0, row_reg} + DIM_W'(1)) >= h_eff;
        x_over = ({2'b0, dest_x_reg} + {1'b0, rect_width_reg}) > {1'b0, screen_width_reg};
        y_over = ({2'b0, dest_y_reg} + {1'b0, rect_height_reg}) > {1'b0, screen_height_reg};

        info.row_sum      = {1'b0, dest_y_reg} + {1'b0, row_reg};
        info.col_sum      = {1'b0, dest_x_reg} + {1'b0, col_reg};
        info.screen_width = screen_width_reg;
        info.bad          = !rw_ok || !rh_ok || !sw_ok || !sh_ok || x_over || y_over;
        info.last         = last_col && last_row;
        info.mode         = blit_mode_reg;
        info.wide         = wide_pixels_reg;
    end

    always_comb
    begin
        dest_x_next        = dest_x_reg;
        dest_y_next        = dest_y_reg;
        rect_width_next    = rect_width_reg;
        rect_height_next   = rect_height_reg;
        screen_width_next  = screen_width_reg;
        screen_height_next = screen_height_reg;
        blit_mode_next     = blit_mode_reg;
        wide_pixels_next   = wide_pixels_reg;
        col_next           = col_reg;
        row_next           = row_reg;
        if (cfg_we)
        begin
            // any write restarts the walk
            col_next = '0;
            row_next = '0;
            unique case (cfg_index)
                CFG_DEST_X:        dest_x_next        = cfg_data[POS_W-1:0];
                CFG_DEST_Y:        dest_y_next        = cfg_data[POS_W-1:0];
                CFG_RECT_WIDTH:    rect_width_next    = cfg_data;
                CFG_RECT_HEIGHT:   rect_height_next   = cfg_data;
                CFG_SCREEN_WIDTH:  screen_width_next  = cfg_data;
                CFG_SCREEN_HEIGHT: screen_height_next = cfg_data;
                CFG_BLIT_MODE:     blit_mode_next     = cfg_data[1:0];
                CFG_WIDE_PIXELS:   wide_pixels_next   = cfg_data[0];
            endcase
        end
        else if (step)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + POS_W'(1);
            end
            else
            begin
                col_next = col_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dest_x_reg        <= '0;
            dest_y_reg        <= '0;
            rect_width_reg    <= DIM_W'(1);
            rect_height_reg   <= DIM_W'(1);
            screen_width_reg  <= DIM_W'(320);
            screen_height_reg <= DIM_W'(200);
            blit_mode_reg     <= MODE_OPAQUE;
            wide_pixels_reg   <= 1'b0;
            col_reg           <= '0;
            row_reg           <= '0;
        end
        else
        begin
            dest_x_reg        <= dest_x_next;
            dest_y_reg        <= dest_y_next;
            rect_width_reg    <= rect_width_next;
            rect_height_reg   <= rect_height_next;
            screen_width_reg  <= screen_width_next;
            screen_height_reg <= screen_height_next;
            blit_mode_reg     <= blit_mode_next;
            wide_pixels_reg   <= wide_pixels_next;
            col_reg           <= col_next;
            row_reg           <= row_next;
        end
    end

endmodule
